// ===== src/clkc_pkg.sv =====
// ----------------------------------------------------------------------------
// clkc_pkg
// Types, constants and keyword tables shared by the console line keyword
// classifier modules.
// ----------------------------------------------------------------------------
package clkc_pkg;

   localparam int unsigned LINE_LIMIT = 160;   // longest line before a forced flush
   localparam int unsigned HIST_DEPTH = 17;    // longest keyword
   localparam int unsigned HIST_W     = HIST_DEPTH * 8;
   localparam int unsigned KW_COUNT   = 38;
   localparam int unsigned CNT_W      = 32;

   localparam logic [1:0] CAT_SHELL = 2'd0;
   localparam logic [1:0] CAT_CREDS = 2'd1;
   localparam logic [1:0] CAT_KEYS  = 2'd2;
   localparam logic [1:0] CAT_BOOT  = 2'd3;

   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_TILDE  = 8'h7e;
   localparam logic [7:0] CHR_UPPER_A = 8'h41;
   localparam logic [7:0] CHR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CHR_HASH   = 8'h23;
   localparam logic [7:0] CHR_DOLLAR = 8'h24;
   localparam logic [7:0] CHR_EQUAL  = 8'h3d;
   localparam logic [7:0] CHR_GT     = 8'h3e;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   // Keywords are right-justified: byte 0 holds the last character, which
   // lines up with the newest byte of the history. Unused bytes are zero.
   localparam logic [HIST_W-1:0] KW_TEXT [KW_COUNT] = '{
      HIST_W'("login:"),            HIST_W'("password:"),
      HIST_W'("root@"),             HIST_W'({"bus", "ybox"}),
      HIST_W'("/bin/sh"),           HIST_W'("/bin/ash"),
      HIST_W'("uid=0"),             HIST_W'("command not found"),
      HIST_W'("~ #"),               HIST_W'("console:"),
      HIST_W'("psk="),              HIST_W'("psk:"),
      HIST_W'("passphrase"),        HIST_W'({"wpa_", "passphrase"}),
      HIST_W'("ssid="),             HIST_W'("secret="),
      HIST_W'("secret:"),           HIST_W'("token="),
      HIST_W'("token:"),            HIST_W'("bearer "),
      HIST_W'("api_key"),           HIST_W'("apikey"),
      HIST_W'("pass="),             HIST_W'("pwd="),
      HIST_W'("-----begin"),        HIST_W'("ssh-rsa"),
      HIST_W'("ssh-ed25519"),       HIST_W'("private key"),
      HIST_W'({"a", "ws_secret"}),  HIST_W'({"a", "ws_access"}),
      HIST_W'({"u-", "boot"}),      HIST_W'("hit any key"),
      HIST_W'("bootloader"),        HIST_W'("starting kernel"),
      HIST_W'("autoboot"),          HIST_W'({"zep", "hyr"}),
      HIST_W'("reset cause"),       HIST_W'("bootargs")
   };

   localparam logic [1:0] KW_CAT [KW_COUNT] = '{
      CAT_SHELL, CAT_SHELL, CAT_SHELL, CAT_SHELL, CAT_SHELL,
      CAT_SHELL, CAT_SHELL, CAT_SHELL, CAT_SHELL, CAT_SHELL,
      CAT_CREDS, CAT_CREDS, CAT_CREDS, CAT_CREDS, CAT_CREDS,
      CAT_CREDS, CAT_CREDS, CAT_CREDS, CAT_CREDS, CAT_CREDS,
      CAT_CREDS, CAT_CREDS, CAT_CREDS, CAT_CREDS,
      CAT_KEYS,  CAT_KEYS,  CAT_KEYS,  CAT_KEYS,  CAT_KEYS,  CAT_KEYS,
      CAT_BOOT,  CAT_BOOT,  CAT_BOOT,  CAT_BOOT,
      CAT_BOOT,  CAT_BOOT,  CAT_BOOT,  CAT_BOOT
   };

   typedef struct packed {
      logic [3:0]       hit_mask;
      logic [1:0]       primary_category;
      logic [CNT_W-1:0] shell_count;
      logic [CNT_W-1:0] creds_count;
      logic [CNT_W-1:0] keys_count;
      logic [CNT_W-1:0] boot_count;
      logic [CNT_W-1:0] lines_hit_total;
   } result_type;

   // Category hits for keywords ending at the newest history byte. The
   // history is zero past the line start, so a keyword longer than the
   // line never matches.
   function automatic logic [3:0] kw_flags(input logic [HIST_W-1:0] hist);
      logic [3:0] flags;
      logic       hit;
      flags = 4'b0;
      for (int k = 0; k < KW_COUNT; k++) begin
         hit = 1'b1;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            if (KW_TEXT[k][i*8 +: 8] != 8'h00 && KW_TEXT[k][i*8 +: 8] != hist[i*8 +: 8]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            flags[KW_CAT[k]] = 1'b1;
         end
      end
      return flags;
   endfunction

endpackage

// ===== src/console_line_keyword_classifier.sv =====
// ----------------------------------------------------------------------------
// console_line_keyword_classifier
// Splits console bytes into lines and flags lines that carry shell,
// credential, key or boot keywords.
// ----------------------------------------------------------------------------
// Usage:
//   req_*: one console byte per transfer. CR, LF, any control byte and any
//   byte above 126 end the current line; a line is also flushed when a new
//   printable byte would make it longer than 160 characters.
//   rsp_*: one transfer per non-empty line with at least one hit, carrying
//   the hit mask, the primary category and the running counters
//   (all wrap at 2^32). Lines without hits produce nothing.
//   rsp_valid comes from the result queue register, which takes a line's result
//   from the input register once the queue is not full. Throughput: one
//   byte per cycle while req_stall is low; every byte is classified by the
//   parallel keyword comparators on a 17-byte history register.
//   Reset clears the line state, the counters and the result queue.
//   When rsp_stall is held, the two-entry result queue fills; from then on
//   req_stall is high whenever a byte waits in the input register.
//   req_stall never depends combinationally on rsp_stall.
// ----------------------------------------------------------------------------
module console_line_keyword_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_hit_mask,
   output logic [1:0]  rsp_primary_category,
   output logic [31:0] rsp_shell_count,
   output logic [31:0] rsp_creds_count,
   output logic [31:0] rsp_keys_count,
   output logic [31:0] rsp_boot_count,
   output logic [31:0] rsp_lines_hit_total
);
   import clkc_pkg::*;

   logic       push;
   logic       queue_full;
   result_type push_data;
   result_type rsp_data;

   clkc_classifier u_classifier (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .queue_full  (queue_full),
      .push        (push),
      .result      (push_data)
   );

   clkc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_hit_mask         = rsp_data.hit_mask;
   assign rsp_primary_category = rsp_data.primary_category;
   assign rsp_shell_count      = rsp_data.shell_count;
   assign rsp_creds_count      = rsp_data.creds_count;
   assign rsp_keys_count       = rsp_data.keys_count;
   assign rsp_boot_count       = rsp_data.boot_count;
   assign rsp_lines_hit_total  = rsp_data.lines_hit_total;

endmodule

// ===== src/clkc_classifier.sv =====
// ----------------------------------------------------------------------------
// clkc_classifier
// Input register, line state, keyword match and hit counters. Produces at
// most one result per byte for the response queue.
// ----------------------------------------------------------------------------
module clkc_classifier (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_rx_byte,
   input  logic                queue_full,
   output logic                push,
   output clkc_pkg::result_type result
);
   import clkc_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic [7:0]        s1_byte_ff,  s1_byte_in;

   logic [7:0]        len_ff,    len_in;
   logic [HIST_W-1:0] hist_ff,   hist_in;
   logic [3:0]        flags_ff,  flags_in;
   logic [7:0]        last_ff,   last_in;
   logic [7:0]        before_ff, before_in;
   logic              seen_ff,   seen_in;
   logic [3:0][CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0]  total_ff,  total_in;

   logic              advance;
   logic              accept;
   logic              printable;
   logic              flush;
   logic              shell_end;
   logic [3:0]        mask;
   logic [7:0]        low;
   logic [7:0]        len_base;
   logic [HIST_W-1:0] hist_base;
   logic [3:0]        flags_base;
   logic [7:0]        last_base;
   logic [7:0]        before_base;
   logic              seen_base;
   logic [HIST_W-1:0] hist_shift;

   assign advance   = s1_valid_ff && !queue_full;
   assign req_stall = s1_valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_rx_byte;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   assign printable = (s1_byte_ff >= CHR_SPACE) && (s1_byte_ff <= CHR_TILDE);
   assign flush     = !printable || (len_ff >= 8'(LINE_LIMIT));
   assign low       = ((s1_byte_ff >= CHR_UPPER_A) && (s1_byte_ff <= CHR_UPPER_Z))
                      ? (s1_byte_ff | CASE_BIT) : s1_byte_ff;

   // Prompt check on the pending line: ends in '#', '$' or "=>"
   assign shell_end = seen_ff && ((last_ff == CHR_HASH) || (last_ff == CHR_DOLLAR) ||
                                  ((before_ff == CHR_EQUAL) && (last_ff == CHR_GT)));
   assign mask      = flags_ff | {3'b000, shell_end};
   assign push      = advance && flush && (len_ff != 8'd0) && (mask != 4'd0);

   always_comb begin
      if (flush) begin
         len_base    = 8'd0;
         hist_base   = '0;
         flags_base  = 4'd0;
         last_base   = 8'd0;
         before_base = 8'd0;
         seen_base   = 1'b0;
      end else begin
         len_base    = len_ff;
         hist_base   = hist_ff;
         flags_base  = flags_ff;
         last_base   = last_ff;
         before_base = before_ff;
         seen_base   = seen_ff;
      end
   end

   assign hist_shift = {hist_base[HIST_W-9:0], low};

   always_comb begin
      len_in    = len_ff;
      hist_in   = hist_ff;
      flags_in  = flags_ff;
      last_in   = last_ff;
      before_in = before_ff;
      seen_in   = seen_ff;
      if (advance) begin
         if (printable) begin
            hist_in   = hist_shift;
            len_in    = (len_base == 8'hff) ? len_base : len_base + 8'd1;
            flags_in  = flags_base | kw_flags(hist_shift);
            last_in   = last_base;
            before_in = before_base;
            seen_in   = seen_base;
            if (s1_byte_ff != CHR_SPACE) begin
               before_in = hist_base[7:0];
               last_in   = s1_byte_ff;
               seen_in   = 1'b1;
            end
         end else begin
            len_in    = 8'd0;
            hist_in   = '0;
            flags_in  = 4'd0;
            last_in   = 8'd0;
            before_in = 8'd0;
            seen_in   = 1'b0;
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         cnt_in[c] = cnt_ff[c] + {{(CNT_W-1){1'b0}}, push && mask[c]};
      end
      total_in = total_ff + {{(CNT_W-1){1'b0}}, push};
   end

   always_comb begin
      result.hit_mask = mask;
      priority if (mask[CAT_KEYS]) begin
         result.primary_category = CAT_KEYS;
      end else if (mask[CAT_CREDS]) begin
         result.primary_category = CAT_CREDS;
      end else if (mask[CAT_SHELL]) begin
         result.primary_category = CAT_SHELL;
      end else begin
         result.primary_category = CAT_BOOT;
      end
      result.shell_count     = cnt_in[CAT_SHELL];
      result.creds_count     = cnt_in[CAT_CREDS];
      result.keys_count      = cnt_in[CAT_KEYS];
      result.boot_count      = cnt_in[CAT_BOOT];
      result.lines_hit_total = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         len_ff      <= 8'd0;
         hist_ff     <= '0;
         flags_ff    <= 4'd0;
         last_ff     <= 8'd0;
         before_ff   <= 8'd0;
         seen_ff     <= 1'b0;
         cnt_ff      <= '0;
         total_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         len_ff      <= len_in;
         hist_ff     <= hist_in;
         flags_ff    <= flags_in;
         last_ff     <= last_in;
         before_ff   <= before_in;
         seen_ff     <= seen_in;
         cnt_ff      <= cnt_in;
         total_ff    <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
   end

   a_push_has_hit: assert property (@(posedge clock) disable iff (reset)
      push |-> (result.hit_mask != 4'd0 && len_ff != 8'd0))
      else $error("result pushed without a hit or for an empty line");

   a_total_steps: assert property (@(posedge clock) disable iff (reset)
      push |=> (total_ff == $past(total_ff) + 32'd1))
      else $error("hit line total did not advance on a result");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= 8'(LINE_LIMIT))
      else $error("line length ran past the limit");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !push)
      else $error("result pushed into a full queue");

endmodule

// ===== src/clkc_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// clkc_rsp_queue
// Two-entry circular result queue with read and write pointers, so the
// classifier can push one more result after the receiver stalls.
// ----------------------------------------------------------------------------
module clkc_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  clkc_pkg::result_type push_data,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output clkc_pkg::result_type rsp_data
);
   import clkc_pkg::*;

   result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

   a_head_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && rsp_data == $past(rsp_data)))
      else $error("stalled result changed");

endmodule
